[sv/bf_pkg.sv]
package bf_pkg;

	localparam logic [1:0] FUNC_RANGE   = 2'd0;
	localparam logic [1:0] FUNC_SPATIAL = 2'd1;
	localparam logic [1:0] FUNC_PIXEL   = 2'd2;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
	localparam logic [CFG_DATA_W-1:0] RESET_WIDTH  = 11'd640;
	localparam logic [CFG_DATA_W-1:0] RESET_HEIGHT = 11'd480;

	// wide enough for an 11-bit register and for a size up to 4096
	localparam int SIZE_CMP_W = 13;
	localparam int QUO_W      = 12;

	typedef struct packed {
		logic [1:0]  func;
		logic [7:0]  table_index;
		logic [15:0] weight_value;
		logic [7:0]  pixel;
	} in_item_t;

	typedef struct packed {
		logic [11:0] filtered_value;
		logic [9:0]  out_row;
		logic [9:0]  out_col;
	} out_item_t;

	typedef enum logic [1:0] {
		KIND_RANGE,
		KIND_SPATIAL,
		KIND_PIXEL
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  index;
		logic [15:0] weight;
		logic [7:0]  pixel;
	} q_item_t;

	typedef struct packed {
		logic [CFG_DATA_W-1:0] width;
		logic [CFG_DATA_W-1:0] height;
	} frame_size_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_SHIFT,
		ST_ACC,
		ST_DRAIN,
		ST_DIV,
		ST_OUT
	} state_t;

endpackage

[sv/bilateral_filter_gray_top.sv]
// Flow of an interior pixel after acceptance: pop, line read, shift, weighting of the
// window, 12 divide steps, handoff. A border-centre pixel skips weighting and divide.
// Throughput: one item at a time in the back end; it pops a new item only when the last
// one is through, and it takes weight writes in its idle state.
// Reset: arst_n clears control state; the line memories are then zeroed by a
// clearing pass over all MAX_WIDTH addresses during which no item leaves the queue.
module bilateral_filter_gray_top #(
	parameter int DIAMETER   = 5,
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  bf_pkg::in_item_t                    in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output bf_pkg::out_item_t                   out_data,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [bf_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [bf_pkg::CFG_DATA_W-1:0]       cfg_data
);

	// Frame size registers; writes to unknown indexes are dropped.
	bf_pkg::frame_size_t size_q;

	// Queue between classifier and filter engine.
	logic              q_valid, q_pop;
	bf_pkg::q_item_t   q_item;

	// Result handoff into the output register.
	logic              res_valid, res_ready;
	bf_pkg::out_item_t res;
	logic              out_valid_q;
	bf_pkg::out_item_t out_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q.width  <= bf_pkg::RESET_WIDTH;
			size_q.height <= bf_pkg::RESET_HEIGHT;
		end else if (cfg_valid) begin
			case (cfg_index)
				bf_pkg::CFG_WIDTH:  size_q.width  <= cfg_data;
				bf_pkg::CFG_HEIGHT: size_q.height <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Front: takes items, drops no-op ones, queues the rest in order.
	bf_front #(
		.DIAMETER(DIAMETER)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop)
	);

	// Back: table writes, line buffers, window, weighted sum and divider.
	bf_back #(
		.DIAMETER  (DIAMETER),
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.sizes     (size_q),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// Output register: the engine hands off and goes on while the item waits.
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

[sv/bf_front.sv]
module bf_front #(
	parameter int DIAMETER = 5
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  bf_pkg::in_item_t  in_data,
	output logic              q_valid,
	output bf_pkg::q_item_t   q_item,
	input  logic              q_pop
);

	localparam int NW = DIAMETER * DIAMETER;

	bf_pkg::q_item_t ent_q [2];
	logic            wp_q, rp_q;
	logic [1:0]      cnt_q;
	logic            keep, push;
	bf_pkg::q_item_t cls;

	// classify; func 3 and out-of-table spatial writes are dropped here
	always_comb begin
		cls.index  = in_data.table_index;
		cls.weight = in_data.weight_value;
		cls.pixel  = in_data.pixel;
		cls.kind   = bf_pkg::KIND_PIXEL;
		keep       = 1'b0;
		case (in_data.func)
			bf_pkg::FUNC_RANGE: begin
				cls.kind = bf_pkg::KIND_RANGE;
				keep     = 1'b1;
			end
			bf_pkg::FUNC_SPATIAL: begin
				cls.kind = bf_pkg::KIND_SPATIAL;
				keep     = int'(in_data.table_index) < NW;
			end
			bf_pkg::FUNC_PIXEL: begin
				cls.kind = bf_pkg::KIND_PIXEL;
				keep     = 1'b1;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign in_ready = (cnt_q != 2'd2);
	assign push     = in_valid && in_ready && keep;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_item   = ent_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (q_pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end

endmodule

[sv/bf_back.sv]
module bf_back #(
	parameter int DIAMETER   = 5,
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  bf_pkg::frame_size_t sizes,
	input  logic                q_valid,
	input  bf_pkg::q_item_t     q_item,
	output logic                q_pop,
	output logic                res_valid,
	input  logic                res_ready,
	output bf_pkg::out_item_t   res
);

	localparam int NW     = DIAMETER * DIAMETER;
	localparam int HALF   = DIAMETER / 2;
	localparam int LAG    = DIAMETER - 1 - HALF;
	localparam int LINES  = DIAMETER - 1;
	localparam int CENTRE = HALF * DIAMETER + HALF;
	localparam int CW     = $clog2(MAX_WIDTH);
	localparam int RW     = $clog2(MAX_HEIGHT);
	localparam int KW     = $clog2(NW);
	localparam int SW     = $clog2(LINES);
	localparam int SCW    = bf_pkg::SIZE_CMP_W;
	localparam int QW     = bf_pkg::QUO_W;
	localparam int DEN_W  = 32 + KW;
	localparam int NUM_W  = DEN_W + 8;
	localparam int REM_W  = NUM_W + 5;
	localparam int DSH_W  = DEN_W + QW - 1;

	bf_pkg::state_t state_q, state_d;

	logic [CW-1:0]    clr_q, col_q;
	logic [RW-1:0]    row_q;
	logic [SW-1:0]    slot_q;
	logic [7:0]       px_q;
	logic [7:0]       win_q [NW];
	logic [7:0]       line_rd [LINES];
	logic [7:0]       col_in [LINES];
	logic [KW-1:0]    k_q;
	logic [15:0]      rtab [256];
	logic [15:0]      stab [NW];
	logic [15:0]      rw_s1, sw_s1;
	logic [7:0]       q_s1, q_s2;
	logic             v_s1, v_s2;
	logic [31:0]      w_s2;
	logic [39:0]      wq;
	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;
	logic [REM_W-1:0] rem_q;
	logic [DSH_W-1:0] dsh_q;
	logic [QW-1:0]    quo_q, quo_d;
	logic [3:0]       bit_q;
	bf_pkg::out_item_t res_q;

	logic [SCW-1:0] w_use, h_use, wx, hx;
	logic           row_end, frame_end, emit, interior, acc_done, div_take;
	logic [7:0]     sel_px, centre, diff;
	logic [RW-1:0]  r_lag;
	logic [CW-1:0]  c_lag;

	// sizes in use, clamped to 1..MAX
	always_comb begin
		wx = SCW'(sizes.width);
		hx = SCW'(sizes.height);
		if (wx == '0) w_use = SCW'(1);
		else if (wx > SCW'(MAX_WIDTH)) w_use = SCW'(MAX_WIDTH);
		else w_use = wx;
		if (hx == '0) h_use = SCW'(1);
		else if (hx > SCW'(MAX_HEIGHT)) h_use = SCW'(MAX_HEIGHT);
		else h_use = hx;
	end

	assign row_end   = (SCW'(col_q) + SCW'(1)) >= w_use;
	assign frame_end = (SCW'(row_q) + SCW'(1)) >= h_use;
	assign emit      = (int'(row_q) >= LAG) && (int'(col_q) >= LAG);
	assign interior  = (int'(row_q) >= DIAMETER - 1) && (int'(col_q) >= DIAMETER - 1);
	assign r_lag     = row_q - RW'(LAG);
	assign c_lag     = col_q - CW'(LAG);
	assign acc_done  = !v_s1 && !v_s2;

	assign sel_px = win_q[k_q];
	assign centre = win_q[CENTRE];
	assign diff   = (sel_px > centre) ? sel_px - centre : centre - sel_px;

	assign wq = 40'(w_s2) * 40'(q_s2);

	assign div_take = REM_W'(dsh_q) <= rem_q;
	always_comb begin
		quo_d = quo_q;
		if (div_take) begin
			quo_d[bit_q] = 1'b1;
		end
	end

	// new window column: line i comes from slot (slot_q + i) wrapped at LINES
	always_comb begin
		for (int i = 0; i < LINES; i++) begin
			if (int'(slot_q) + i >= LINES) begin
				col_in[i] = line_rd[SW'(int'(slot_q) + i - LINES)];
			end else begin
				col_in[i] = line_rd[SW'(int'(slot_q) + i)];
			end
		end
	end

	// line memories, one per stored line
	for (genvar l = 0; l < LINES; l++) begin : g_line
		logic [7:0] mem [MAX_WIDTH];
		logic [7:0] rd_q;
		always_ff @(posedge clk) begin
			if (state_q == bf_pkg::ST_CLEAR) begin
				mem[clr_q] <= 8'd0;
			end else if (state_q == bf_pkg::ST_SHIFT && slot_q == SW'(l)) begin
				mem[col_q] <= px_q;
			end
			if (state_q == bf_pkg::ST_READ) begin
				rd_q <= mem[col_q];
			end
		end
		assign line_rd[l] = rd_q;
	end

	// weight tables
	always_ff @(posedge clk) begin
		if (state_q == bf_pkg::ST_IDLE && q_valid) begin
			if (q_item.kind == bf_pkg::KIND_RANGE) begin
				rtab[q_item.index] <= q_item.weight;
			end
			if (q_item.kind == bf_pkg::KIND_SPATIAL) begin
				stab[q_item.index[KW-1:0]] <= q_item.weight;
			end
		end
		rw_s1 <= rtab[diff];
		sw_s1 <= stab[k_q];
	end

	// FSM
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bf_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		q_pop     = 1'b0;
		res_valid = 1'b0;
		case (state_q)
			bf_pkg::ST_CLEAR: begin
				if (clr_q == CW'(MAX_WIDTH - 1)) state_d = bf_pkg::ST_IDLE;
			end
			bf_pkg::ST_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					if (q_item.kind == bf_pkg::KIND_PIXEL) state_d = bf_pkg::ST_READ;
				end
			end
			bf_pkg::ST_READ: begin
				state_d = bf_pkg::ST_SHIFT;
			end
			bf_pkg::ST_SHIFT: begin
				if (!emit) state_d = bf_pkg::ST_IDLE;
				else if (!interior) state_d = bf_pkg::ST_OUT;
				else state_d = bf_pkg::ST_ACC;
			end
			bf_pkg::ST_ACC: begin
				if (k_q == KW'(NW - 1)) state_d = bf_pkg::ST_DRAIN;
			end
			bf_pkg::ST_DRAIN: begin
				if (acc_done) begin
					state_d = (den_q == '0) ? bf_pkg::ST_OUT : bf_pkg::ST_DIV;
				end
			end
			bf_pkg::ST_DIV: begin
				if (bit_q == 4'd0) state_d = bf_pkg::ST_OUT;
			end
			bf_pkg::ST_OUT: begin
				res_valid = 1'b1;
				if (res_ready) state_d = bf_pkg::ST_IDLE;
			end
			default: begin
				state_d = bf_pkg::ST_IDLE;
			end
		endcase
	end

	// control counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			col_q  <= '0;
			row_q  <= '0;
			slot_q <= '0;
			k_q    <= '0;
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			for (int i = 0; i < NW; i++) win_q[i] <= 8'd0;
		end else begin
			v_s1 <= (state_q == bf_pkg::ST_ACC);
			v_s2 <= v_s1;
			if (state_q == bf_pkg::ST_CLEAR) begin
				clr_q <= clr_q + CW'(1);
			end
			if (state_q == bf_pkg::ST_ACC) begin
				k_q <= k_q + KW'(1);
			end else begin
				k_q <= '0;
			end
			if (state_q == bf_pkg::ST_SHIFT) begin
				for (int i = 0; i < DIAMETER; i++) begin
					for (int j = 0; j < DIAMETER - 1; j++) begin
						win_q[i*DIAMETER+j] <= win_q[i*DIAMETER+j+1];
					end
				end
				for (int i = 0; i < LINES; i++) begin
					win_q[i*DIAMETER+DIAMETER-1] <= col_in[i];
				end
				win_q[NW-1] <= px_q;
				if (row_end) begin
					col_q <= '0;
					if (frame_end) begin
						row_q  <= '0;
						slot_q <= '0;
					end else begin
						row_q  <= row_q + RW'(1);
						slot_q <= (slot_q == SW'(LINES - 1)) ? '0 : slot_q + SW'(1);
					end
				end else begin
					col_q <= col_q + CW'(1);
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		q_s1 <= sel_px;
		w_s2 <= rw_s1 * sw_s1;
		q_s2 <= q_s1;
		if (state_q == bf_pkg::ST_IDLE && q_valid) begin
			px_q <= q_item.pixel;
		end
		if (state_q == bf_pkg::ST_SHIFT) begin
			num_q                <= '0;
			den_q                <= '0;
			res_q.filtered_value <= '0;
			res_q.out_row        <= 10'(r_lag);
			res_q.out_col        <= 10'(c_lag);
		end else if (v_s2) begin
			num_q <= num_q + NUM_W'(wq);
			den_q <= den_q + DEN_W'(w_s2);
		end
		if (state_q == bf_pkg::ST_DRAIN && acc_done) begin
			res_q.filtered_value <= {centre, 4'd0};
			rem_q <= REM_W'({num_q, 4'd0}) + REM_W'(den_q >> 1);
			dsh_q <= DSH_W'(den_q) << (QW - 1);
			quo_q <= '0;
			bit_q <= 4'(QW - 1);
		end
		if (state_q == bf_pkg::ST_DIV) begin
			if (div_take) rem_q <= rem_q - REM_W'(dsh_q);
			dsh_q <= dsh_q >> 1;
			quo_q <= quo_d;
			bit_q <= bit_q - 4'd1;
			if (bit_q == 4'd0) res_q.filtered_value <= quo_d;
		end
	end

	assign res = res_q;

	a_pipe_order: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> $past(v_s1))
		else $error("accumulate stage without a weight stage before it");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bf_pkg::ST_DIV) |-> (dsh_q != '0))
		else $error("division running with zero divisor");

	a_res_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.filtered_value <= 12'd4080))
		else $error("filtered value above 255.0");

endmodule

[test/bilateral_filter_gray_top_tb.sv]
module bilateral_filter_gray_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DIAM   = 5;
	localparam int HALF   = DIAM / 2;
	localparam int LAG    = DIAM - 1 - HALF;
	localparam int LINES  = DIAM - 1;
	localparam int MAXW   = 1024;
	localparam int MAXH   = 1024;
	// unused func code, must be ignored by the block
	localparam logic [1:0] FUNC_NONE = 2'd3;
	// margin after the last result, covering the worst interior pixel, before touching registers
	localparam int SETTLE_CYCLES = 80;
	localparam int STALL_LIMIT   = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	bf_pkg::in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	bf_pkg::out_item_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [bf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [bf_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	bilateral_filter_gray_top u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// Filter predictor: own copy of line memory, window, tables, counters
	// ---------------------------------------------------------------
	logic [7:0]  line_mem [LINES*MAXW];
	logic [7:0]  win [DIAM][DIAM];
	logic [15:0] range_w [256];
	logic [15:0] spatial_w [DIAM*DIAM];
	int unsigned row_cnt, col_cnt;
	logic [bf_pkg::CFG_DATA_W-1:0] width_reg, height_reg;

	bf_pkg::out_item_t filtered_q[$];   // expected results, oldest first
	int errors = 0;
	bit no_idle = 1'b0;        // set during the idle-free stretch

	function automatic int unsigned clamp_size(int unsigned v, int unsigned maxv);
		if (v < 1) return 1;
		if (v > maxv) return maxv;
		return v;
	endfunction

	function automatic logic [11:0] weighted_mean();
		longint unsigned num, den, w;
		int unsigned p, q, d;
		num = 0;
		den = 0;
		p = win[HALF][HALF];
		for (int i = 0; i < DIAM; i++) begin
			for (int j = 0; j < DIAM; j++) begin
				q = win[i][j];
				d = (q > p) ? q - p : p - q;
				w = longint'(range_w[d]) * longint'(spatial_w[i*DIAM+j]);
				num += w * q;
				den += w;
			end
		end
		if (den == 0) return 12'(p << 4);
		return 12'((num * 16 + den / 2) / den);
	endfunction

	// Applies one accepted item; pushes a result when the centre is in range.
	task automatic apply_item(bf_pkg::in_item_t it);
		int unsigned r, c, w, h, slot;
		logic [11:0] v;
		bf_pkg::out_item_t res;
		r = row_cnt;
		c = col_cnt;
		w = clamp_size(width_reg, MAXW);
		h = clamp_size(height_reg, MAXH);
		if (it.func == bf_pkg::FUNC_RANGE) begin
			range_w[it.table_index] = it.weight_value;
		end else if (it.func == bf_pkg::FUNC_SPATIAL) begin
			if (it.table_index < DIAM*DIAM) spatial_w[it.table_index] = it.weight_value;
		end else if (it.func == bf_pkg::FUNC_PIXEL) begin
			if (c >= MAXW) c = MAXW - 1;
			for (int i = 0; i < DIAM; i++)
				for (int j = 0; j < DIAM - 1; j++)
					win[i][j] = win[i][j+1];
			for (int i = 0; i < LINES; i++) begin
				slot = (r + i) % LINES;
				win[i][DIAM-1] = line_mem[slot*MAXW + c];
			end
			win[DIAM-1][DIAM-1] = it.pixel;
			line_mem[(r % LINES)*MAXW + c] = it.pixel;
			if (r >= LAG && c >= LAG) begin
				v = '0;
				if (r >= DIAM - 1 && c >= DIAM - 1) v = weighted_mean();
				res.filtered_value = v;
				res.out_row = 10'(r - LAG);
				res.out_col = 10'(c - LAG);
				filtered_q.push_back(res);
			end
			if (c + 1 >= w) begin
				col_cnt = 0;
				row_cnt = (r + 1 >= h) ? 0 : r + 1;
			end else begin
				col_cnt = c + 1;
			end
		end
	endtask

	// ---------------------------------------------------------------
	// Driving
	// ---------------------------------------------------------------
	function automatic bit take_gap();
		return !no_idle && ($urandom_range(0, 99) < 20);
	endfunction

	// One item: random gap, then hold valid until accepted.
	task automatic send_item(bf_pkg::in_item_t it);
		if (take_gap()) begin
			in_valid <= 1'b0;
			do @(posedge clk); while (take_gap());
		end
		in_data <= it;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		apply_item(it);
	endtask

	task automatic send_pixel(logic [7:0] px);
		bf_pkg::in_item_t it;
		it.func = bf_pkg::FUNC_PIXEL;
		it.table_index = 8'($urandom);
		it.weight_value = 16'($urandom);
		it.pixel = px;
		send_item(it);
	endtask

	task automatic send_weight(logic [1:0] f, logic [7:0] idx, logic [15:0] val);
		bf_pkg::in_item_t it;
		it.func = f;
		it.table_index = idx;
		it.weight_value = val;
		it.pixel = 8'($urandom);
		send_item(it);
	endtask

	// Wait until every expected result is out and the back end is quiet.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (filtered_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [bf_pkg::CFG_IDX_W-1:0] idx,
			logic [bf_pkg::CFG_DATA_W-1:0] val);
		drain();
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == bf_pkg::CFG_WIDTH) width_reg = val;
		else if (idx == bf_pkg::CFG_HEIGHT) height_reg = val;
	endtask

	task automatic set_size(logic [bf_pkg::CFG_DATA_W-1:0] w,
			logic [bf_pkg::CFG_DATA_W-1:0] h);
		write_reg(bf_pkg::CFG_WIDTH, w);
		write_reg(bf_pkg::CFG_HEIGHT, h);
	endtask

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------
	// Fill both tables before any pixel can read them; also out-of-range
	// spatial indexes and the unused func code, which change nothing.
	task automatic test_table_load();
		send_weight(bf_pkg::FUNC_RANGE, 8'd0, 16'hFFFF);
		for (int i = 1; i < 256; i++)
			send_weight(bf_pkg::FUNC_RANGE, 8'(i), (i == 255) ? 16'h0000 : 16'($urandom));
		for (int i = 0; i < DIAM*DIAM; i++)
			send_weight(bf_pkg::FUNC_SPATIAL, 8'(i), 16'($urandom_range(1, 65535)));
		send_weight(bf_pkg::FUNC_SPATIAL, 8'(DIAM*DIAM), 16'h1234);
		send_weight(bf_pkg::FUNC_SPATIAL, 8'hFF, 16'hFFFF);
		send_weight(FUNC_NONE, 8'hFF, 16'hFFFF);
		send_weight(FUNC_NONE, 8'h00, 16'h0000);
	endtask

	// 5x5 frame, the smallest with an interior pixel, extreme pixel values so all 8 bits toggle.
	task automatic test_small_frame();
		set_size(11'd5, 11'd5);
		for (int i = 0; i < 2*25; i++)
			send_pixel((i % 3 == 0) ? 8'hFF : ((i % 3 == 1) ? 8'h00 : 8'($urandom)));
	endtask

	// All spatial weights zero: result falls back to centre pixel in 8.4.
	task automatic test_zero_weight_sum();
		for (int i = 0; i < DIAM*DIAM; i++)
			send_weight(bf_pkg::FUNC_SPATIAL, 8'(i), 16'h0000);
		for (int i = 0; i < 25; i++) send_pixel(8'($urandom));
		for (int i = 0; i < DIAM*DIAM; i++)
			send_weight(bf_pkg::FUNC_SPATIAL, 8'(i), 16'($urandom_range(1, 65535)));
	endtask

	// Register values outside the useful range get clamped.
	task automatic test_clamped_sizes();
		set_size(11'd0, 11'd0);
		for (int i = 0; i < 10; i++) send_pixel(8'($urandom));
		set_size(11'd1, 11'd1);
		for (int i = 0; i < 5; i++) send_pixel(8'($urandom));
		// registers above the maximum, short run at the start of a row
		set_size(11'h7FF, 11'h7FF);
		for (int i = 0; i < 40; i++) send_pixel(8'($urandom));
		set_size(11'd1024, 11'd1024);
		for (int i = 0; i < 30; i++) send_pixel(8'($urandom));
	endtask

	// Random phases: mostly pixels at small sizes, some weight rewrites and noise.
	task automatic test_random_stream();
		int n, k;
		for (int ph = 0; ph < 8; ph++) begin
			set_size(11'($urandom_range(5, 40)), 11'($urandom_range(5, 20)));
			n = 100;
			for (int i = 0; i < n; i++) begin
				no_idle = (ph == 3);   // one long stretch without gaps
				k = $urandom_range(0, 99);
				if (k < 90)
					send_pixel(8'($urandom));
				else if (k < 94)
					send_weight(bf_pkg::FUNC_RANGE, 8'($urandom), 16'($urandom));
				else if (k < 97)
					send_weight(bf_pkg::FUNC_SPATIAL,
						($urandom_range(0, 3) == 0) ? 8'($urandom) :
						8'($urandom_range(0, DIAM*DIAM-1)), 16'($urandom));
				else
					send_weight(FUNC_NONE, 8'($urandom), 16'($urandom));
			end
		end
		no_idle = 1'b0;
	endtask

	// ---------------------------------------------------------------
	// Result checker, receiver stalls, stall watchdog
	// ---------------------------------------------------------------
	int stall_cnt = 0;
	always @(posedge clk) begin
		bf_pkg::out_item_t exp_r;
		out_ready <= no_idle || ($urandom_range(0, 99) >= 20);
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			stall_cnt <= 0;
		else
			stall_cnt <= stall_cnt + 1;
		if (arst_n && out_valid && out_ready) begin
			if (filtered_q.size() == 0) begin
				$error("unexpected result row %0d col %0d", out_data.out_row, out_data.out_col);
				errors++;
			end else begin
				exp_r = filtered_q.pop_front();
				if (out_data.filtered_value !== exp_r.filtered_value) begin
					$error("filtered_value exp %0d got %0d", exp_r.filtered_value,
						out_data.filtered_value);
					errors++;
				end
				if (out_data.out_row !== exp_r.out_row) begin
					$error("out_row exp %0d got %0d", exp_r.out_row, out_data.out_row);
					errors++;
				end
				if (out_data.out_col !== exp_r.out_col) begin
					$error("out_col exp %0d got %0d", exp_r.out_col, out_data.out_col);
					errors++;
				end
			end
		end
		if (stall_cnt >= STALL_LIMIT) begin
			$display("bilateral_filter_gray_top test failed");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < LINES*MAXW; i++) line_mem[i] = '0;
		for (int i = 0; i < DIAM; i++)
			for (int j = 0; j < DIAM; j++) win[i][j] = '0;
		for (int i = 0; i < 256; i++) range_w[i] = '0;
		for (int i = 0; i < DIAM*DIAM; i++) spatial_w[i] = '0;
		row_cnt = 0;
		col_cnt = 0;
		width_reg = bf_pkg::RESET_WIDTH;
		height_reg = bf_pkg::RESET_HEIGHT;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		test_table_load();
		// a few pixels at the reset size before any register write
		for (int i = 0; i < 10; i++) send_pixel(8'($urandom));
		test_small_frame();
		test_zero_weight_sum();
		test_clamped_sizes();
		test_random_stream();

		drain();
		if (errors == 0 && filtered_q.size() == 0) begin
			$display("bilateral_filter_gray_top test passed");
		end else begin
			$display("bilateral_filter_gray_top test failed");
		end
		$finish;
	end

endmodule

[files.f]
sv/bf_pkg.sv
sv/bf_front.sv
sv/bf_back.sv
sv/bilateral_filter_gray_top.sv
test/bilateral_filter_gray_top_tb.sv
